// ===== rtl/dop_pkg.sv =====
package dop_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int RT_FRAC   = 24;
   localparam int SPLIT     = 24;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int CF_DIV_W  = 48;   // |water * cFr| and |J| << 16
   localparam int SQ_W      = 64;   // cF^2, bath^2 and their sum
   localparam int Q_DIV_W   = 63;   // cF^2 numerator of cF^2 / osm
   localparam int R_W       = 48;   // width of J / D ratio

   localparam logic [16:0] ONE_Q = 17'h1_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_SF = 3'd0,
      CSR_SOLID  = 3'd1,
      CSR_WATER  = 3'd2,
      CSR_BATH   = 3'd3,
      CSR_RTPHI  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_DENOM = 2'd1,
      ERR_OSM   = 2'd2
   } error_type;

   typedef struct packed {
      logic err_den;
      logic cf_neg;
      logic j_neg;
   } div_side_type;

   typedef struct packed {
      logic               err_den;
      logic               j_neg;
      logic [31:0]        cf;
      logic [SQ_W-1:0]    sq;
      logic [R_W-1:0]     r;
   } sqrt_side_type;

   typedef struct packed {
      logic               err_den;
      logic               err_osm;
      logic               j_neg;
      logic [31:0]        cf;
      logic [30:0]        osm;
      logic [30:0]        p;
      logic [R_W-1:0]     r;
   } qdiv_side_type;

endpackage

// ===== rtl/dop_div.sv =====
module dop_div #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   // one quotient bit per stage, restoring
   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  nq_ff    [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              v_src;
      logic [DEN_W-1:0]  rem_src;
      logic [NUM_W-1:0]  nq_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  nq_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign nq_src   = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign nq_src   = nq_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         trial  = {rem_src, nq_src[NUM_W-1]};
         diff   = trial - {1'b0, den_src};
         ge     = (trial >= {1'b0, den_src});
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         nq_in  = {nq_src[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/dop_sqrt.sv =====
module dop_sqrt #(
   parameter int IN_W   = 64,
   parameter int SIDE_W = 146
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [IN_W-1:0]    in_val,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [IN_W/2-1:0]  out_root,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   // one root bit per stage
   logic              valid_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [IN_W-1:0]   val_ff   [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [IN_W-1:0]   val_src;
      logic [SIDE_W-1:0] side_src;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [IN_W-1:0]   val_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign val_src  = in_val;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign val_src  = val_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         cur     = {rem_src, val_src[IN_W-1 -: 2]};
         trial   = {2'b00, root_src, 2'b01};
         diff    = cur - trial;
         ge      = (cur >= trial);
         rem_in  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
         root_in = {root_src[ROOT_W-2:0], ge};
         val_in  = {val_src[IN_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            val_ff[k]  <= val_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== rtl/donnan_osmotic_pressure_top.sv =====
// Donnan osmotic pressure, one material point per word. A point goes in on
// req_ and results leave on rsp_ in the order the points were taken; a new
// point can enter in every cycle unless rsp_ stalls. The depth is set by the
// bit-serial pipelines: the 48-stage divider for the charge density and the
// J ratio, the 32-stage square root for the osmolarity and the 63-stage
// divider for cF^2 / osm, plus ten stages of multiply and saturate logic. The
// whole pipeline holds while a result waits on rsp_ with rsp_tready low.
// Error codes come out on rsp_tuser; an error zeroes the value fields.
module donnan_osmotic_pressure_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // volume_ratio [31:0], ref_charge [63:32]
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // charge_density [31:0], osmolarity [62:32], pressure [94:63],
   // pressure_tangent [126:95], zero [127]
   output logic [127:0] rsp_tdata,
   // error [1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [dop_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dop_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DW = dop_pkg::DATA_W;

   logic        en;
   logic        use_sf_ff;
   logic [16:0] solid_ff;
   logic [16:0] water_ff;
   logic [30:0] bath_ff;
   logic [31:0] rtphi_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         use_sf_ff <= 1'b0;
         solid_ff  <= '0;
         water_ff  <= dop_pkg::ONE_Q;
         bath_ff   <= '0;
         rtphi_ff  <= '0;
      end else if (csr_we) begin
         case (dop_pkg::csr_index_type'(csr_index))
            dop_pkg::CSR_USE_SF: use_sf_ff <= csr_wdata[0];
            dop_pkg::CSR_SOLID:  solid_ff  <= csr_wdata[16:0];
            dop_pkg::CSR_WATER:  water_ff  <= csr_wdata[16:0];
            dop_pkg::CSR_BATH:   bath_ff   <= csr_wdata[30:0];
            dop_pkg::CSR_RTPHI:  rtphi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold everything while the output word is not taken
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: capture
   logic               s1_valid_ff;
   logic signed [31:0] s1_j_ff;
   logic signed [31:0] s1_c_ff;

   // stage 2: denominator and water * cFr
   logic               s2_valid_ff;
   logic signed [31:0] s2_j_ff;
   logic signed [33:0] s2_denom_ff;
   logic signed [49:0] s2_prod_ff;
   logic signed [33:0] denom_in;
   logic signed [49:0] prod_in;

   always_comb begin
      if (use_sf_ff) begin
         denom_in = {{2{s1_j_ff[31]}}, s1_j_ff} - $signed(34'(solid_ff));
      end else begin
         denom_in = {{2{s1_j_ff[31]}}, s1_j_ff} - $signed(34'(dop_pkg::ONE_Q))
                    + $signed(34'(water_ff));
      end
      prod_in = $signed({1'b0, water_ff}) * s1_c_ff;
   end

   // stage 3: magnitudes for the dividers
   logic                            s3_valid_ff;
   logic [dop_pkg::CF_DIV_W-1:0]    s3_num_ff;
   logic [dop_pkg::CF_DIV_W-1:0]    s3_jnum_ff;
   logic [31:0]                     s3_den_ff;
   dop_pkg::div_side_type           s3_side_ff;
   logic [49:0]                     prod_abs;
   logic [31:0]                     j_abs;
   dop_pkg::div_side_type           side3_in;

   always_comb begin
      prod_abs = s2_prod_ff[49] ? (50'd0 - s2_prod_ff) : s2_prod_ff;
      j_abs    = s2_j_ff[31] ? (32'd0 - s2_j_ff) : s2_j_ff;
      side3_in.err_den = s2_denom_ff[33] || (s2_denom_ff == '0);
      side3_in.cf_neg  = s2_prod_ff[49];
      side3_in.j_neg   = s2_j_ff[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s1_j_ff     <= req_tdata[31:0];
         s1_c_ff     <= req_tdata[63:32];
         s2_j_ff     <= s1_j_ff;
         s2_denom_ff <= denom_in;
         s2_prod_ff  <= prod_in;
         s3_num_ff   <= prod_abs[dop_pkg::CF_DIV_W-1:0];
         s3_jnum_ff  <= {j_abs, 16'd0};
         s3_den_ff   <= s2_denom_ff[31:0];
         s3_side_ff  <= side3_in;
      end
   end

   // cF = water * cFr / D and r = |J| * 2^16 / D in parallel
   logic                          cfd_valid;
   logic [dop_pkg::CF_DIV_W-1:0]  cfd_quo;
   dop_pkg::div_side_type         cfd_side;
   logic                          rd_valid;
   logic [dop_pkg::CF_DIV_W-1:0]  rd_quo;
   logic                          rd_side;

   dop_div #(
      .NUM_W  (dop_pkg::CF_DIV_W),
      .DEN_W  (32),
      .SIDE_W ($bits(dop_pkg::div_side_type))
   ) u_cf_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (cfd_valid),
      .out_quo   (cfd_quo),
      .out_side  (cfd_side)
   );

   dop_div #(
      .NUM_W  (dop_pkg::CF_DIV_W),
      .DEN_W  (32),
      .SIDE_W (1)
   ) u_r_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_jnum_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff.j_neg),
      .out_valid (rd_valid),
      .out_quo   (rd_quo),
      .out_side  (rd_side)
   );

   // stage 4: saturate cF
   logic               s4_valid_ff;
   logic [31:0]        s4_cf_ff;
   logic [31:0]        s4_ucf_ff;
   logic [47:0]        s4_r_ff;
   logic               s4_err_ff;
   logic               s4_jneg_ff;
   logic [31:0]        cf_in;
   logic [31:0]        ucf_in;
   logic [47:0]        neg_q;

   always_comb begin
      neg_q = 48'd0 - cfd_quo;
      if (cfd_side.cf_neg) begin
         if (cfd_quo > 48'h0000_8000_0000) begin
            cf_in  = 32'h8000_0000;
            ucf_in = 32'h8000_0000;
         end else begin
            cf_in  = neg_q[31:0];
            ucf_in = cfd_quo[31:0];
         end
      end else begin
         if (cfd_quo > 48'h0000_7FFF_FFFF) begin
            cf_in  = 32'h7FFF_FFFF;
            ucf_in = 32'h7FFF_FFFF;
         end else begin
            cf_in  = cfd_quo[31:0];
            ucf_in = cfd_quo[31:0];
         end
      end
   end

   // stage 5: squares
   logic               s5_valid_ff;
   logic [63:0]        s5_sq_ff;
   logic [61:0]        s5_bb_ff;
   logic [31:0]        s5_cf_ff;
   logic [47:0]        s5_r_ff;
   logic               s5_err_ff;
   logic               s5_jneg_ff;
   logic [63:0]        sq_in;
   logic [61:0]        bb_in;

   assign sq_in = s4_ucf_ff * s4_ucf_ff;
   assign bb_in = bath_ff * bath_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= cfd_valid && rd_valid;
         s5_valid_ff <= s4_valid_ff;
      end
      if (en) begin
         s4_cf_ff   <= cf_in;
         s4_ucf_ff  <= ucf_in;
         s4_r_ff    <= rd_quo;
         s4_err_ff  <= cfd_side.err_den;
         s4_jneg_ff <= rd_side;
         s5_sq_ff   <= sq_in;
         s5_bb_ff   <= bb_in;
         s5_cf_ff   <= s4_cf_ff;
         s5_r_ff    <= s4_r_ff;
         s5_err_ff  <= s4_err_ff;
         s5_jneg_ff <= s4_jneg_ff;
      end
   end

   // osm = floor(sqrt(cF^2 + bath^2))
   dop_pkg::sqrt_side_type sq_side_in;
   dop_pkg::sqrt_side_type sq_side_out;
   logic                   sqrt_valid;
   logic [31:0]            sqrt_root;
   logic [63:0]            sum_in;

   always_comb begin
      sum_in              = s5_sq_ff + 64'(s5_bb_ff);
      sq_side_in.err_den  = s5_err_ff;
      sq_side_in.j_neg    = s5_jneg_ff;
      sq_side_in.cf       = s5_cf_ff;
      sq_side_in.sq       = s5_sq_ff;
      sq_side_in.r        = s5_r_ff;
   end

   dop_sqrt #(
      .IN_W   (dop_pkg::SQ_W),
      .SIDE_W ($bits(dop_pkg::sqrt_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_val    (sum_in),
      .in_side   (sq_side_in),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sq_side_out)
   );

   // stage 6: capture root; stage 7: pressure product
   logic                   s6_valid_ff;
   logic [31:0]            s6_osm_ff;
   dop_pkg::sqrt_side_type s6_side_ff;
   logic                   s7_valid_ff;
   logic [31:0]            s7_osm_ff;
   logic [63:0]            s7_pmul_ff;
   dop_pkg::sqrt_side_type s7_side_ff;
   logic [31:0]            diff_in;
   logic [63:0]            pmul_in;

   assign diff_in = s6_osm_ff - 32'(bath_ff);
   assign pmul_in = rtphi_ff * diff_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= sqrt_valid;
         s7_valid_ff <= s6_valid_ff;
      end
      if (en) begin
         s6_osm_ff  <= sqrt_root;
         s6_side_ff <= sq_side_out;
         s7_osm_ff  <= s6_osm_ff;
         s7_pmul_ff <= pmul_in;
         s7_side_ff <= s6_side_ff;
      end
   end

   // q = cF^2 / osm
   dop_pkg::qdiv_side_type qd_side_in;
   dop_pkg::qdiv_side_type qd_side_out;
   logic                   qd_valid;
   logic [dop_pkg::Q_DIV_W-1:0] qd_quo;
   logic [39:0]            p_hi;

   always_comb begin
      p_hi               = s7_pmul_ff[63:dop_pkg::RT_FRAC];
      qd_side_in.err_den = s7_side_ff.err_den;
      qd_side_in.err_osm = (s7_osm_ff == '0);
      qd_side_in.j_neg   = s7_side_ff.j_neg;
      qd_side_in.cf      = s7_side_ff.cf;
      qd_side_in.osm     = (s7_osm_ff > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : s7_osm_ff[30:0];
      qd_side_in.p       = (p_hi > 40'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : p_hi[30:0];
      qd_side_in.r       = s7_side_ff.r;
   end

   dop_div #(
      .NUM_W  (dop_pkg::Q_DIV_W),
      .DEN_W  (32),
      .SIDE_W ($bits(dop_pkg::qdiv_side_type))
   ) u_q_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_valid_ff),
      .in_num    (s7_side_ff.sq[dop_pkg::Q_DIV_W-1:0]),
      .in_den    (s7_osm_ff),
      .in_side   (qd_side_in),
      .out_valid (qd_valid),
      .out_quo   (qd_quo),
      .out_side  (qd_side_out)
   );

   // stage 8: q * rt_phi; stage 9: split product with r
   logic                   s8_valid_ff;
   logic [63:0]            s8_aprod_ff;
   dop_pkg::qdiv_side_type s8_side_ff;
   logic                   s9_valid_ff;
   logic [63:0]            s9_hi_ff;
   logic [63:0]            s9_lo_ff;
   dop_pkg::qdiv_side_type s9_side_ff;
   logic [63:0]            aprod_in;
   logic [39:0]            a_val;
   logic [63:0]            hi_in;
   logic [63:0]            lo_in;

   always_comb begin
      aprod_in = qd_quo[31:0] * rtphi_ff;
      a_val    = s8_aprod_ff[63:dop_pkg::RT_FRAC];
      hi_in    = a_val * s8_side_ff.r[dop_pkg::R_W-1:dop_pkg::SPLIT];
      lo_in    = a_val * s8_side_ff.r[dop_pkg::SPLIT-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (en) begin
         s8_valid_ff <= qd_valid;
         s9_valid_ff <= s8_valid_ff;
      end
      if (en) begin
         s8_aprod_ff <= aprod_in;
         s8_side_ff  <= qd_side_out;
         s9_hi_ff    <= hi_in;
         s9_lo_ff    <= lo_in;
         s9_side_ff  <= s8_side_ff;
      end
   end

   // output stage: tangent magnitude, sign, error masking
   localparam int HI_SH = dop_pkg::SPLIT - dop_pkg::FRAC_BITS;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_cd_ff;
   logic [30:0]           rsp_osm_ff;
   logic [30:0]           rsp_p_ff;
   logic [31:0]           rsp_tan_ff;
   dop_pkg::error_type    rsp_err_ff;
   logic [48:0]           mag_sum;
   logic [32:0]           mag;
   logic [32:0]           neg_mag;
   logic [31:0]           tan_val;
   logic [31:0]           cd_in;
   logic [30:0]           osm_in;
   logic [30:0]           p_in;
   logic [31:0]           tan_in;
   dop_pkg::error_type    err_in;

   always_comb begin
      if (s9_hi_ff >= 64'(1) << (DW - 1 - HI_SH)) begin
         mag_sum = 49'(1) << (DW - 1);
      end else begin
         mag_sum = 49'({s9_hi_ff[DW-2-HI_SH:0], {HI_SH{1'b0}}})
                   + 49'(s9_lo_ff[63:dop_pkg::FRAC_BITS]);
      end
      mag     = (mag_sum > (49'(1) << (DW - 1))) ? 33'h0_8000_0000 : mag_sum[32:0];
      neg_mag = 33'd0 - mag;
      if (s9_side_ff.j_neg) begin
         tan_val = neg_mag[31:0];
      end else begin
         tan_val = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end

      if (s9_side_ff.err_den) begin
         cd_in  = '0;
         osm_in = '0;
         p_in   = '0;
         tan_in = '0;
         err_in = dop_pkg::ERR_DENOM;
      end else if (s9_side_ff.err_osm) begin
         cd_in  = '0;
         osm_in = '0;
         p_in   = '0;
         tan_in = '0;
         err_in = dop_pkg::ERR_OSM;
      end else begin
         cd_in  = s9_side_ff.cf;
         osm_in = s9_side_ff.osm;
         p_in   = s9_side_ff.p;
         tan_in = tan_val;
         err_in = dop_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s9_valid_ff;
      end
      if (en) begin
         rsp_cd_ff  <= cd_in;
         rsp_osm_ff <= osm_in;
         rsp_p_ff   <= p_in;
         rsp_tan_ff <= tan_in;
         rsp_err_ff <= err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_tan_ff, 1'b0, rsp_p_ff, rsp_osm_ff, rsp_cd_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== tb/sv/donnan_osmotic_pressure_checker.sv =====
module donnan_osmotic_pressure_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [63:0]                      req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [127:0]                     rsp_tdata,
   input  logic [1:0]                       rsp_tuser,
   input  logic                             csr_we,
   input  logic [dop_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dop_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               mismatch_count,
   output int                               points_pending,
   output int                               points_checked
);

   typedef struct packed {
      logic [31:0]        charge;
      logic [30:0]        osm;
      logic [31:0]        pressure;
      logic [31:0]        tangent;
      dop_pkg::error_type err;
   } point_result_type;

   localparam longint SAT_MAX = 64'sd2147483647;
   localparam longint SAT_MIN = -64'sd2147483648;

   logic [63:0] sf_mode, solid_q, water_q, bath_q, rt_q;
   point_result_type expected_q[$];

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic point_result_type donnan_predict(logic [31:0] j_word,
                                                       logic [31:0] c_word);
      longint j, c, den, cf, tn;
      logic [63:0] ucf, sq, osm, diff, p, q, a, uj, r, hi, lo, mag;
      point_result_type res;
      res = '0;
      res.err = dop_pkg::ERR_NONE;
      j = longint'($signed(j_word));
      c = longint'($signed(c_word));
      if (sf_mode[0])
         den = j - longint'(solid_q);
      else
         den = j - longint'(dop_pkg::ONE_Q) + longint'(water_q);
      if (den <= 0) begin
         res.err = dop_pkg::ERR_DENOM;
         return res;
      end
      cf = (longint'(water_q) * c) / den;
      if (cf > SAT_MAX) cf = SAT_MAX;
      if (cf < SAT_MIN) cf = SAT_MIN;
      ucf = (cf < 0) ? 64'(-cf) : 64'(cf);
      sq = ucf * ucf;
      osm = int_sqrt(sq + bath_q * bath_q);
      if (osm == 0) begin
         res.err = dop_pkg::ERR_OSM;
         return res;
      end
      res.charge = cf[31:0];
      res.osm = (osm > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : osm[30:0];
      diff = osm - bath_q;
      p = (rt_q * diff) >> dop_pkg::RT_FRAC;
      if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
      res.pressure = p[31:0];
      q = sq / osm;
      a = (q * rt_q) >> dop_pkg::RT_FRAC;
      uj = (j < 0) ? 64'(-j) : 64'(j);
      r = (uj << dop_pkg::FRAC_BITS) / 64'(den);
      hi = a * (r >> dop_pkg::SPLIT);
      lo = a * (r & ((64'd1 << dop_pkg::SPLIT) - 1));
      if (hi >= (64'd1 << (dop_pkg::DATA_W - 1 - (dop_pkg::SPLIT - dop_pkg::FRAC_BITS))))
         mag = 64'd1 << (dop_pkg::DATA_W - 1);
      else
         mag = (hi << (dop_pkg::SPLIT - dop_pkg::FRAC_BITS)) + (lo >> dop_pkg::FRAC_BITS);
      if (mag > (64'd1 << (dop_pkg::DATA_W - 1))) mag = 64'd1 << (dop_pkg::DATA_W - 1);
      if (j < 0)
         tn = -longint'(mag);
      else
         tn = (mag > 64'h7FFF_FFFF) ? SAT_MAX : longint'(mag);
      res.tangent = tn[31:0];
      return res;
   endfunction

   function automatic void report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
         if (mismatch_count < 10)
            $display("mismatch %s: expected %h got %h", name, exp_v, got_v);
         mismatch_count++;
      end
   endfunction

   // Handshakes are sampled mid-cycle, where every signal has settled.
   always @(negedge clock) begin
      point_result_type exp_r;
      if (reset) begin
         sf_mode = 0;
         solid_q = 0;
         water_q = 64'd65536;
         bath_q  = 0;
         rt_q    = 0;
         expected_q.delete();
         mismatch_count = 0;
         points_checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               dop_pkg::CSR_USE_SF: sf_mode = {63'd0, csr_wdata[0]};
               dop_pkg::CSR_SOLID:  solid_q = {47'd0, csr_wdata[16:0]};
               dop_pkg::CSR_WATER:  water_q = {47'd0, csr_wdata[16:0]};
               dop_pkg::CSR_BATH:   bath_q  = {33'd0, csr_wdata[30:0]};
               dop_pkg::CSR_RTPHI:  rt_q    = {32'd0, csr_wdata};
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               if (mismatch_count < 10) $display("mismatch: result word with none expected");
               mismatch_count++;
            end else begin
               exp_r = expected_q.pop_front();
               report_field("charge_density", 64'(exp_r.charge), 64'(rsp_tdata[31:0]));
               report_field("osmolarity", 64'(exp_r.osm), 64'(rsp_tdata[62:32]));
               report_field("pressure", 64'(exp_r.pressure), 64'(rsp_tdata[94:63]));
               report_field("pressure_tangent", 64'(exp_r.tangent), 64'(rsp_tdata[126:95]));
               report_field("pad", 64'd0, 64'(rsp_tdata[127]));
               report_field("error", 64'(exp_r.err), 64'(rsp_tuser));
            end
            points_checked++;
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(donnan_predict(req_tdata[31:0], req_tdata[63:32]));
      end
      points_pending = expected_q.size();
   end

endmodule

// ===== tb/sv/tb_donnan_osmotic_pressure_top.sv =====
module tb_donnan_osmotic_pressure_top;

   localparam int  LATENCY_WAIT = 200;
   localparam int  CYCLE_LIMIT  = 300000;
   localparam logic [dop_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [31:0] ONE_J = 32'h0001_0000;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [63:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [127:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we;
   logic [dop_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dop_pkg::CSR_DATA_W-1:0] csr_wdata;
   int mismatch_count, points_pending, points_checked;
   int points_sent;
   longint cycle_count = 0;

   donnan_osmotic_pressure_top u_dut (.*);

   donnan_osmotic_pressure_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d points pending", points_pending);
         $display("tb_donnan_osmotic_pressure_top: FAIL");
         $finish;
      end
   end

   // Receiver: random stalls per word, plus one long hold-off to back up the pipe.
   initial begin
      int gap;
      bit held;
      rsp_tready = 0;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && points_checked >= 60) begin
            held = 1;
            rsp_tready <= 0;
            repeat (600) @(posedge clock);
         end
         gap = (points_checked % 150 < 40) ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
      end
   end

   task automatic send_point(logic [31:0] j, logic [31:0] c);
      int gap;
      gap = (points_sent % 120 < 30) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {c, j};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      points_sent++;
   endtask

   task automatic write_csr(logic [dop_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 0;
   endtask

   task automatic drain_pipe();
      req_tvalid <= 0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic load_settings(logic sf, logic [31:0] solid, logic [31:0] water,
                                logic [31:0] bath, logic [31:0] rt);
      write_csr(dop_pkg::CSR_USE_SF, {31'd0, sf});
      write_csr(dop_pkg::CSR_SOLID, solid);
      write_csr(dop_pkg::CSR_WATER, water);
      write_csr(dop_pkg::CSR_BATH, bath);
      write_csr(dop_pkg::CSR_RTPHI, rt);
   endtask

   function automatic logic [31:0] pick_ratio();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return ONE_J + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
         2: return $urandom_range(0, 32'h0010_0000);
         3: return -$urandom_range(0, 32'h0002_0000);
         default: return ONE_J + ($urandom() & 32'h0000_FFFF);
      endcase
   endfunction

   function automatic logic [31:0] pick_charge();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         2: return 32'h0;
         default: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
      endcase
   endfunction

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_index = dop_pkg::CSR_USE_SF;
      csr_wdata = '0;
      points_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: zero charge with zero bath hits the osmolarity error
      send_point(ONE_J, 32'h0);
      send_point(ONE_J, ONE_J);
      send_point(ONE_J, 32'hFFFF_0000);
      send_point(32'h0, ONE_J);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h0000_0001, 32'h7FFF_FFFF);
      send_point(32'h0000_0001, 32'h8000_0000);
      drain_pipe();

      load_settings(1'b0, 32'h0, 32'h0000_C000, 32'h0002_0000, 32'h0100_0000);
      send_point(ONE_J, 32'h0);
      send_point(32'h0000_4000, 32'h0);
      send_point(32'h0000_4001, 32'h0003_0000);
      send_point(32'hFFFF_8000, 32'h0001_0000);
      send_point(32'h0002_0000, 32'hFFFD_0000);
      send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      drain_pipe();

      // extremes of the registers but water, some with bits beyond the field range
      load_settings(1'b1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE, 32'hDEAD_BEEF);
      send_point(32'h0001_0000, ONE_J);
      send_point(32'h0001_FFFF, ONE_J);
      send_point(32'h0002_0000, 32'h7FFF_FFFF);
      send_point(32'h0000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h0000_0001, 32'h7FFF_FFFF);
      drain_pipe();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: load_settings(1'b0, 32'h0, 32'h0001_0000, 32'h0, 32'h0280_0000);
            1: load_settings(1'b1, $urandom_range(0, 65536), $urandom_range(0, 65536),
                             $urandom_range(0, 32'h0010_0000), $urandom());
            2: load_settings(1'b0, 32'h0001_0000, 32'h0, $urandom(), 32'h0);
            default: load_settings(1'b1, 32'h0, $urandom_range(0, 65536),
                                   $urandom_range(0, 32'h0000_4000), $urandom());
         endcase
         for (int k = 0; k < 110; k++) send_point(pick_ratio(), pick_charge());
         drain_pipe();
      end

      $display("ran %0d points through %0d results over directed extremes and seven",
               points_sent, points_checked);
      $display("register settings, with random idles and one long output hold-off");
      if (mismatch_count == 0 && points_pending == 0)
         $display("tb_donnan_osmotic_pressure_top: PASS");
      else
         $display("tb_donnan_osmotic_pressure_top: FAIL");
      $finish;
   end

endmodule
